// ===== design/sfdi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdi_pkg
// Shared types, constants and the sat16 helper function of the stereo feedback delay.
// ----------------------------------------------------------------------------
package sfdi_pkg;

	localparam int BUF_AW    = 19;
	localparam int BUF_DEPTH = 1 << BUF_AW;
	localparam int CHANNELS  = 2;

	localparam logic [35:0] CLIP_K27 = 36'd28991029248;
	localparam logic [19:0] CLIP_LIM = 20'd98304;
	localparam logic signed [15:0] SMP_MAX = 16'sd32767;
	localparam logic signed [15:0] SMP_MIN = -16'sd32768;

	typedef enum logic [2:0] {
		REG_FB_GAIN = 3'd0,
		REG_SMOOTH  = 3'd1,
		REG_LATTEN  = 3'd2,
		REG_RATTEN  = 3'd3,
		REG_HARD    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] in_left;
		logic signed [15:0] in_right;
		logic signed [15:0] mix_left;
		logic signed [15:0] mix_right;
		logic [26:0]        target_delay;
		logic [15:0]        target_gain;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
	} out_item_t;

	typedef struct packed {
		logic [BUF_AW-1:0] addr0;
		logic [BUF_AW-1:0] addr1;
		logic [BUF_AW-1:0] wr_addr;
		logic              vld0;
		logic              vld1;
		logic [7:0]        frac;
		logic [31:0]       gain;
		logic [15:0]       fb_gain;
		logic              hard;
	} lane_cmd_t;

	function automatic logic signed [15:0] sat16(input logic signed [19:0] x);
		logic signed [15:0] r;
		if (x > 20'sd32767) begin
			r = SMP_MAX;
		end else if (x < -20'sd32768) begin
			r = SMP_MIN;
		end else begin
			r = x[15:0];
		end
		return r;
	endfunction

endpackage

// ===== design/sfdi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdi_if
// Valid/ready channels carrying input frames and output frames.
// ----------------------------------------------------------------------------
interface sfdi_in_if;
	import sfdi_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sfdi_out_if;
	import sfdi_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/stereo_feedback_delay_interp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_interp_core
// Stereo fractional feedback delay with linear interpolation and clipping.
//
// Frames enter on din as valid/ready beats and leave on dout one beat per
// frame. Registers are written through cfg_we, cfg_idx and cfg_wdata; the user
// must do so only while no frame is in flight, which the block does not enforce.
// A frame is taken only while the block is idle. The smoother state and then
// the read address state run, each channel lane then reads its store twice,
// interpolates, scales and runs two clip units side by side. The output beat
// becomes valid once both lanes are idle again, and only then can the next
// frame be taken. In soft clip mode, for inputs below the clip limit, the
// output clip unit also runs the square, the numerator and the 17-step
// divider before the lanes finish.
// The finished frame sits in an output register, so the next frame is taken
// while the receiver stalls; a second finished frame waits until that beat
// has gone.
// Reset clears the smoother, the feedback samples, the write position and the
// registers. Store entries not yet written since reset read as zero, tracked
// by the write position and a wrap flag, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_interp_core (
	input  logic        clk,
	input  logic        arst_n,
	sfdi_in_if.sink     din,
	sfdi_out_if.source  dout,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);
	import sfdi_pkg::*;

	typedef enum logic [5:0] {
		T_IDLE   = 6'b000001,
		T_SMOOTH = 6'b000010,
		T_ADDR   = 6'b000100,
		T_RUN    = 6'b001000,
		T_WAIT   = 6'b010000,
		T_OUT    = 6'b100000
	} top_st_t;

	top_st_t            st_q;
	in_item_t           item_q;
	logic [15:0]        fbg_q;
	logic [15:0]        k_q;
	logic [15:0]        latt_q;
	logic [15:0]        ratt_q;
	logic               hard_q;
	logic [39:0]        sd_q;
	logic [31:0]        sg_q;
	logic [BUF_AW-1:0]  wp_q;
	logic               wrap_q;
	lane_cmd_t          cmd_q;
	logic               out_vld_q;
	out_item_t          out_q;

	logic signed [40:0]    dd;
	logic signed [57:0]    dk;
	logic signed [41:0]    sd_sum;
	logic signed [32:0]    dg;
	logic signed [49:0]    dgk;
	logic signed [33:0]    sg_sum;
	logic [BUF_AW+7:0]     dq8;
	logic [BUF_AW+7:0]     rpos;
	logic [BUF_AW-1:0]     ip;
	logic [BUF_AW-1:0]     i0;
	logic [1:0]            lane_busy;
	logic signed [15:0]    lane_res [2];
	logic                  all_idle;
	logic                  out_free;

	assign dd     = $signed({1'b0, item_q.target_delay, 13'd0}) - $signed({1'b0, sd_q});
	assign dk     = dd * $signed({1'b0, k_q});
	assign sd_sum = $signed({2'b00, sd_q}) + dk[57:16];
	assign dg     = $signed({1'b0, item_q.target_gain, 16'd0}) - $signed({1'b0, sg_q});
	assign dgk    = dg * $signed({1'b0, k_q});
	assign sg_sum = $signed({2'b00, sg_q}) + dgk[49:16];

	assign dq8  = (BUF_AW + 8)'(sd_q[39:13]);
	assign rpos = {wp_q, 8'd0} - dq8;
	assign ip   = rpos[BUF_AW+7:8];
	assign i0   = ip - 1'b1;

	assign all_idle = lane_busy == 2'b00;
	assign out_free = !out_vld_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbg_q  <= '0;
			k_q    <= '0;
			latt_q <= 16'd32768;
			ratt_q <= 16'd32768;
			hard_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_FB_GAIN: fbg_q  <= cfg_wdata;
				REG_SMOOTH:  k_q    <= cfg_wdata;
				REG_LATTEN:  latt_q <= cfg_wdata;
				REG_RATTEN:  ratt_q <= cfg_wdata;
				REG_HARD:    hard_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= T_IDLE;
			sd_q      <= '0;
			sg_q      <= '0;
			wp_q      <= '0;
			wrap_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (st_q == T_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (dout.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (st_q)
				T_IDLE: begin
					if (din.valid) begin
						st_q <= T_SMOOTH;
					end
				end
				T_SMOOTH: begin
					sd_q <= sd_sum[39:0];
					sg_q <= sg_sum[31:0];
					st_q <= T_ADDR;
				end
				T_ADDR: st_q <= T_RUN;
				T_RUN: st_q <= T_WAIT;
				T_WAIT: begin
					if (all_idle) begin
						wp_q <= wp_q + 1'b1;
						if (wp_q == BUF_AW'(BUF_DEPTH - 1)) begin
							wrap_q <= 1'b1;
						end
						st_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (out_free) begin
						st_q <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == T_IDLE && din.valid) begin
			item_q <= din.data;
		end
		if (st_q == T_ADDR) begin
			cmd_q.addr0   <= i0;
			cmd_q.addr1   <= ip;
			cmd_q.wr_addr <= wp_q;
			cmd_q.vld0    <= wrap_q || (i0 < wp_q);
			cmd_q.vld1    <= wrap_q || (ip < wp_q);
			cmd_q.frac    <= rpos[7:0];
			cmd_q.gain    <= sg_q;
			cmd_q.fb_gain <= fbg_q;
			cmd_q.hard    <= hard_q;
		end
		if (st_q == T_OUT && out_free) begin
			out_q.out_left  <= lane_res[0];
			out_q.out_right <= lane_res[1];
		end
	end

	for (genvar c = 0; c < 2; c++) begin : g_lane
		if (c < CHANNELS) begin : g_on
			sfdi_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.start  (st_q == T_RUN),
				.cmd    (cmd_q),
				.atten  ((c == 0) ? latt_q : ratt_q),
				.x_in   ((c == 0) ? item_q.in_left : item_q.in_right),
				.mix_in ((c == 0) ? item_q.mix_left : item_q.mix_right),
				.busy   (lane_busy[c]),
				.result (lane_res[c])
			);
		end else begin : g_off
			assign lane_busy[c] = 1'b0;
			assign lane_res[c]  = 16'sd0;
		end
	end

	assign din.ready  = st_q == T_IDLE;
	assign dout.valid = out_vld_q;
	assign dout.data  = out_q;
endmodule

// ===== design/sfdi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sfdi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== design/sfdi_clip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdi_clip
// Hard saturation or rational tanh soft clip with a bit-serial divider.
// ----------------------------------------------------------------------------
module sfdi_clip (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               hard,
	input  logic signed [19:0] x,
	output logic               busy,
	output logic signed [15:0] y
);
	import sfdi_pkg::*;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_SQ   = 4'b0010,
		C_NUM  = 4'b0100,
		C_DIV  = 4'b1000
	} clip_st_t;

	clip_st_t           st_q;
	logic               neg_q;
	logic [16:0]        m_q;
	logic [33:0]        sq_q;
	logic [52:0]        rem_q;
	logic [52:0]        dsh_q;
	logic [16:0]        quo_q;
	logic [4:0]         cnt_q;
	logic signed [15:0] y_q;

	logic [19:0]        mag;
	logic [35:0]        tsum;
	logic [52:0]        num;
	logic [37:0]        den;
	logic               ge;
	logic [16:0]        qn;
	logic signed [19:0] qs;

	assign mag  = x[19] ? 20'(-x) : 20'(x);
	assign tsum = CLIP_K27 + 36'(sq_q);
	assign num  = 53'(m_q) * 53'(tsum);
	assign den  = 38'(CLIP_K27) + 38'({sq_q, 3'b000}) + 38'(sq_q);
	assign ge   = rem_q >= dsh_q;
	assign qn   = {quo_q[15:0], ge};
	assign qs   = neg_q ? -$signed({3'b000, qn}) : $signed({3'b000, qn});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
		end else begin
			unique case (st_q)
				C_IDLE: begin
					if (start && !hard && mag < CLIP_LIM) begin
						st_q <= C_SQ;
					end
				end
				C_SQ: st_q <= C_NUM;
				C_NUM: st_q <= C_DIV;
				C_DIV: begin
					if (cnt_q == 5'd0) begin
						st_q <= C_IDLE;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			C_IDLE: begin
				if (start) begin
					neg_q <= x[19];
					m_q   <= mag[16:0];
					if (hard) begin
						y_q <= sat16(x);
					end else if (mag >= CLIP_LIM) begin
						y_q <= x[19] ? -SMP_MAX : SMP_MAX;
					end
				end
			end
			C_SQ: sq_q <= 34'(m_q) * 34'(m_q);
			C_NUM: begin
				rem_q <= num;
				dsh_q <= {den[36:0], 16'd0};
				quo_q <= '0;
				cnt_q <= 5'd16;
			end
			C_DIV: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= qn;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					y_q <= sat16(qs);
				end
			end
			default: ;
		endcase
	end

	assign busy = st_q != C_IDLE;
	assign y    = y_q;
endmodule

// ===== design/sfdi_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdi_lane
// One channel: delay store, interpolated read, feedback and two clip units.
// ----------------------------------------------------------------------------
module sfdi_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  sfdi_pkg::lane_cmd_t   cmd,
	input  logic [15:0]           atten,
	input  logic signed [15:0]    x_in,
	input  logic signed [15:0]    mix_in,
	output logic                  busy,
	output logic signed [15:0]    result
);
	import sfdi_pkg::*;

	typedef enum logic [7:0] {
		L_IDLE = 8'b00000001,
		L_RD0  = 8'b00000010,
		L_RD1  = 8'b00000100,
		L_INT  = 8'b00001000,
		L_ATT  = 8'b00010000,
		L_WET  = 8'b00100000,
		L_OCL  = 8'b01000000,
		L_FIN  = 8'b10000000
	} lane_st_t;

	lane_st_t           st_q;
	lane_cmd_t          cmd_q;
	logic [15:0]        atten_q;
	logic signed [15:0] x_q;
	logic signed [15:0] mix_q;
	logic signed [15:0] fb_q;
	logic signed [17:0] fbp_q;
	logic signed [15:0] y0_s1;
	logic signed [15:0] smp_s2;
	logic signed [15:0] fbn_s3;
	logic signed [19:0] wet_s4;

	logic [BUF_AW-1:0]  raddr;
	logic [15:0]        rdata;
	logic               ram_we;
	logic signed [15:0] rd_smp;
	logic signed [32:0] fbp_full;
	logic signed [19:0] x_store;
	logic [8:0]         w0;
	logic signed [25:0] p0;
	logic signed [25:0] p1;
	logic signed [25:0] isum;
	logic signed [32:0] ap;
	logic signed [48:0] wp_full;
	logic               s_start;
	logic               o_start;
	logic               s_busy;
	logic               o_busy;
	logic signed [15:0] s_y;
	logic signed [15:0] o_y;

	assign raddr    = (st_q == L_RD0) ? cmd_q.addr0 : cmd_q.addr1;
	assign ram_we   = (st_q == L_FIN) && !s_busy && !o_busy;
	assign rd_smp   = $signed(rdata);
	assign fbp_full = fb_q * $signed({1'b0, cmd_q.fb_gain});
	assign x_store  = {{4{x_q[15]}}, x_q} + {{2{fbp_q[17]}}, fbp_q};
	assign w0       = 9'd256 - {1'b0, cmd_q.frac};
	assign p0       = y0_s1 * $signed({1'b0, w0});
	assign p1       = (cmd_q.vld1 ? rd_smp : 16'sd0) * $signed({2'b00, cmd_q.frac});
	assign isum     = p0 + p1;
	assign ap       = smp_s2 * $signed({1'b0, atten_q});
	assign wp_full  = fbn_s3 * $signed({1'b0, cmd_q.gain});
	assign s_start  = st_q == L_RD1;
	assign o_start  = st_q == L_OCL;

	sfdi_ram #(.WIDTH(16), .DEPTH(BUF_DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd_q.wr_addr),
		.wdata (s_y),
		.raddr (raddr),
		.rdata (rdata)
	);

	sfdi_clip u_clip_store (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s_start),
		.hard   (cmd_q.hard),
		.x      (x_store),
		.busy   (s_busy),
		.y      (s_y)
	);

	sfdi_clip u_clip_out (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (o_start),
		.hard   (cmd_q.hard),
		.x      (wet_s4),
		.busy   (o_busy),
		.y      (o_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			fb_q <= '0;
		end else begin
			unique case (st_q)
				L_IDLE: begin
					if (start) begin
						st_q <= L_RD0;
					end
				end
				L_RD0: st_q <= L_RD1;
				L_RD1: st_q <= L_INT;
				L_INT: st_q <= L_ATT;
				L_ATT: st_q <= L_WET;
				L_WET: st_q <= L_OCL;
				L_OCL: st_q <= L_FIN;
				L_FIN: begin
					if (ram_we) begin
						fb_q <= fbn_s3;
						st_q <= L_IDLE;
					end
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && st_q == L_IDLE) begin
			cmd_q   <= cmd;
			atten_q <= atten;
			x_q     <= x_in;
			mix_q   <= mix_in;
		end
		if (st_q == L_RD0) begin
			fbp_q <= fbp_full[32:15];
		end
		if (st_q == L_RD1) begin
			y0_s1 <= cmd_q.vld0 ? rd_smp : 16'sd0;
		end
		if (st_q == L_INT) begin
			smp_s2 <= isum[23:8];
		end
		if (st_q == L_ATT) begin
			fbn_s3 <= sat16({{2{ap[32]}}, ap[32:15]});
		end
		if (st_q == L_WET) begin
			wet_s4 <= {wp_full[48], wp_full[48:30]} + {{4{mix_q[15]}}, mix_q};
		end
	end

	assign busy   = st_q != L_IDLE;
	assign result = o_y;
endmodule

// ===== design/sfdi_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdi_chk
// Port-level checks on the frame channels of the delay core.
// ----------------------------------------------------------------------------
module sfdi_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_data
);
	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Stalled output beat changed.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("Output beat without a frame taken.");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("More than two frames held inside the block.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("Second frame taken while one is being worked on.");
endmodule

bind stereo_feedback_delay_interp_core sfdi_chk u_sfdi_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_data  (dout.data)
);
